@@ rtl/cspa_pkg.sv @@
// shared types, constants and codes of the chunked slot pool allocator
// no dependencies; used by every module of the block but cspa_ram
package cspa_pkg;

    localparam int TOTAL_SLOTS_DEF = 4096;
    localparam int MAX_CHUNKS_DEF  = 16;
    localparam int CHUNK_CAP_DEF   = 1024;

    localparam int REQ_W    = 2;
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] FIRST_RESET = 11'd64;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GC    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING  = 2'd3;

    typedef enum logic [3:0] {
        S_INIT, S_LINKHEAD, S_LINK, S_IDLE, S_ACT, S_A_RD, S_A_UPD,
        S_F_RD, S_F_CHK, S_F_W2, S_G_RD, S_G_CHK, S_U_RD, S_U_WR, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_CFG, OP_INIT, OP_ACCEPT, OP_ACT, OP_LINKHEAD, OP_LINK,
        OP_A_RD, OP_A_UPD, OP_F_RD, OP_F_W1, OP_F_W2, OP_G_RD, OP_G_CHK,
        OP_U_RD, OP_U_WR, OP_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic                set_status;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic head_valid;
        logic gc_ok;
        logic act_ok;
        logic range_ok;
        logic busy;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/chunked_slot_pool_allocator.sv @@
// Chunked slot pool allocator, top level.
// Depends on cspa_pkg, cspa_ctrl, cspa_dp (which holds the cspa_ram instances).
//
// Requests arrive on the in channel (req_type, slot_index) as a valid/ready
// transfer; each gives exactly one result on the out channel (status,
// granted_slot, active_chunks). The cfg channel writes first_chunk_slots and
// reinitializes the pool; write it only when the block is idle.
// One request is worked on at a time; the sequencer walks link and busy rams.
// Steps from accept to result loaded:
//   alloc with a free slot: read, update; free: check, relink; unknown: none
//   alloc that activates a chunk: activate, link new chunk (one slot per cycle)
//   collect: busy scan of the newest chunk, then unlink of each of its slots;
//   early exit on the first busy slot
// After reset or a cfg write the first chunk is linked one slot per cycle,
// during which no request is taken.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the following request finishes its work and
// then holds until the output register frees.
module chunked_slot_pool_allocator #(
    parameter int TOTAL_SLOTS = cspa_pkg::TOTAL_SLOTS_DEF,
    parameter int MAX_CHUNKS  = cspa_pkg::MAX_CHUNKS_DEF,
    parameter int CHUNK_CAP   = cspa_pkg::CHUNK_CAP_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cspa_pkg::REQ_W-1:0]      i_req_type,
    input  logic [cspa_pkg::SLOT_W-1:0]     i_slot_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cspa_pkg::STATUS_W-1:0]   o_status,
    output logic [cspa_pkg::SLOT_W-1:0]     o_granted_slot,
    output logic [cspa_pkg::CNT_W-1:0]      o_active_chunks,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cspa_pkg::CFG_W-1:0]      i_cfg_data
);

    cspa_pkg::t_dp_cmd  w_cmd;
    cspa_pkg::t_dp_stat w_stat;

    cspa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    cspa_dp #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .MAX_CHUNKS  (MAX_CHUNKS),
        .CHUNK_CAP   (CHUNK_CAP)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_data      (i_cfg_data),
        .i_slot_index    (i_slot_index),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_granted_slot  (o_granted_slot),
        .o_active_chunks (o_active_chunks)
    );

endmodule

@@ rtl/cspa_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module cspa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cspa_ctrl.sv @@
// sequencer of the slot pool allocator: issues one datapath command per cycle
// depends on cspa_pkg
module cspa_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [cspa_pkg::REQ_W-1:0]     i_req_type,
    input  logic                           i_cfg_valid,
    input  cspa_pkg::t_dp_stat             i_stat,
    output logic                           o_in_ready,
    output logic                           o_cfg_ready,
    output cspa_pkg::t_dp_cmd              o_cmd
);

    cspa_pkg::t_state r_state, n_state;
    logic             r_init, n_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cspa_pkg::S_INIT;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_init           = r_init;
        o_cmd.op         = cspa_pkg::OP_NOP;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = cspa_pkg::ST_OK;
        o_in_ready       = 1'b0;
        o_cfg_ready      = 1'b0;
        case (r_state)
            cspa_pkg::S_INIT: begin
                o_cmd.op = cspa_pkg::OP_INIT;
                n_init   = 1'b1;
                n_state  = cspa_pkg::S_LINKHEAD;
            end
            cspa_pkg::S_LINKHEAD: begin
                o_cmd.op = cspa_pkg::OP_LINKHEAD;
                n_state  = cspa_pkg::S_LINK;
            end
            cspa_pkg::S_LINK: begin
                o_cmd.op = cspa_pkg::OP_LINK;
                if (i_stat.last) begin
                    n_state = r_init ? cspa_pkg::S_IDLE : cspa_pkg::S_A_RD;
                end
            end
            cspa_pkg::S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.op = cspa_pkg::OP_CFG;
                    n_state  = cspa_pkg::S_INIT;
                end else if (i_in_valid) begin
                    o_cmd.op = cspa_pkg::OP_ACCEPT;
                    case (i_req_type)
                        cspa_pkg::REQ_ALLOC: begin
                            n_state = i_stat.head_valid ? cspa_pkg::S_A_RD
                                                        : cspa_pkg::S_ACT;
                        end
                        cspa_pkg::REQ_FREE: begin
                            n_state = cspa_pkg::S_F_RD;
                        end
                        cspa_pkg::REQ_GC: begin
                            if (i_stat.gc_ok) begin
                                n_state = cspa_pkg::S_G_RD;
                            end else begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = cspa_pkg::ST_NOTHING;
                                n_state          = cspa_pkg::S_DONE;
                            end
                        end
                        default: begin
                            n_state = cspa_pkg::S_DONE;
                        end
                    endcase
                end
            end
            cspa_pkg::S_ACT: begin
                o_cmd.op = cspa_pkg::OP_ACT;
                n_init   = 1'b0;
                if (i_stat.act_ok) begin
                    n_state = cspa_pkg::S_LINKHEAD;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = cspa_pkg::ST_NO_SPACE;
                    n_state          = cspa_pkg::S_DONE;
                end
            end
            cspa_pkg::S_A_RD: begin
                o_cmd.op = cspa_pkg::OP_A_RD;
                n_state  = cspa_pkg::S_A_UPD;
            end
            cspa_pkg::S_A_UPD: begin
                o_cmd.op = cspa_pkg::OP_A_UPD;
                n_state  = cspa_pkg::S_DONE;
            end
            cspa_pkg::S_F_RD: begin
                o_cmd.op = cspa_pkg::OP_F_RD;
                if (i_stat.range_ok) begin
                    n_state = cspa_pkg::S_F_CHK;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = cspa_pkg::ST_INVALID;
                    n_state          = cspa_pkg::S_DONE;
                end
            end
            cspa_pkg::S_F_CHK: begin
                if (i_stat.busy) begin
                    o_cmd.op = cspa_pkg::OP_F_W1;
                    n_state  = cspa_pkg::S_F_W2;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = cspa_pkg::ST_INVALID;
                    n_state          = cspa_pkg::S_DONE;
                end
            end
            cspa_pkg::S_F_W2: begin
                o_cmd.op = cspa_pkg::OP_F_W2;
                n_state  = cspa_pkg::S_DONE;
            end
            cspa_pkg::S_G_RD: begin
                o_cmd.op = cspa_pkg::OP_G_RD;
                n_state  = cspa_pkg::S_G_CHK;
            end
            cspa_pkg::S_G_CHK: begin
                if (i_stat.busy) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = cspa_pkg::ST_NOTHING;
                    n_state          = cspa_pkg::S_DONE;
                end else begin
                    o_cmd.op = cspa_pkg::OP_G_CHK;
                    n_state  = i_stat.last ? cspa_pkg::S_U_RD : cspa_pkg::S_G_RD;
                end
            end
            cspa_pkg::S_U_RD: begin
                o_cmd.op = cspa_pkg::OP_U_RD;
                n_state  = cspa_pkg::S_U_WR;
            end
            cspa_pkg::S_U_WR: begin
                o_cmd.op = cspa_pkg::OP_U_WR;
                n_state  = i_stat.last ? cspa_pkg::S_DONE : cspa_pkg::S_U_RD;
            end
            cspa_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = cspa_pkg::OP_DONE;
                    n_state  = cspa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cspa_pkg::S_INIT;
            end
        endcase
    end

endmodule

@@ rtl/cspa_dp.sv @@
// datapath of the slot pool allocator: link/busy rams, chunk table, list ends,
// output register; depends on cspa_pkg and cspa_ram
module cspa_dp #(
    parameter int TOTAL_SLOTS = cspa_pkg::TOTAL_SLOTS_DEF,
    parameter int MAX_CHUNKS  = cspa_pkg::MAX_CHUNKS_DEF,
    parameter int CHUNK_CAP   = cspa_pkg::CHUNK_CAP_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cspa_pkg::t_dp_cmd               i_cmd,
    output cspa_pkg::t_dp_stat              o_stat,
    input  logic [cspa_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [cspa_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [cspa_pkg::STATUS_W-1:0]   o_status,
    output logic [cspa_pkg::SLOT_W-1:0]     o_granted_slot,
    output logic [cspa_pkg::CNT_W-1:0]      o_active_chunks
);

    localparam int AW   = $clog2(TOTAL_SLOTS);
    localparam int LW   = AW + 1;
    localparam int MAXL = (TOTAL_SLOTS > CHUNK_CAP) ? TOTAL_SLOTS : CHUNK_CAP;
    localparam int CW   = $clog2(MAXL) + 2;
    localparam int XW   = (CW + 1 > cspa_pkg::SLOT_W + 1) ? CW + 1 : cspa_pkg::SLOT_W + 1;
    localparam int IW   = $clog2(MAX_CHUNKS);
    localparam int KW   = $clog2(MAX_CHUNKS + 1);

    localparam logic [LW-1:0] NONE   = LW'(TOTAL_SLOTS);
    localparam logic [XW-1:0] TOT_X  = XW'(TOTAL_SLOTS);
    localparam logic [CW-1:0] CAP_C  = CW'(CHUNK_CAP);
    localparam logic [KW-1:0] MAXC_K = KW'(MAX_CHUNKS);

    logic [cspa_pkg::CFG_W-1:0]    r_first;
    logic [LW-1:0]                 r_base [MAX_CHUNKS];
    logic [CW-1:0]                 r_len  [MAX_CHUNKS];
    logic [KW-1:0]                 r_count;
    logic [LW-1:0]                 r_head, r_tail, r_lprev, r_i;
    logic [cspa_pkg::SLOT_W-1:0]   r_slot;
    logic [cspa_pkg::STATUS_W-1:0] r_status;
    logic [cspa_pkg::SLOT_W-1:0]   r_granted;
    logic                          r_out_valid;
    logic [cspa_pkg::STATUS_W-1:0] r_out_status;
    logic [cspa_pkg::SLOT_W-1:0]   r_out_granted;
    logic [cspa_pkg::CNT_W-1:0]    r_out_count;

    logic [KW-1:0] w_cm1;
    logic [IW-1:0] w_top, w_cidx;
    logic [LW-1:0] w_nbase, w_i1, w_s_l;
    logic [CW-1:0] w_nlen, w_dbl, w_nnew, w_init_len;
    logic [XW-1:0] w_end, w_s_x;
    logic          w_last, w_act_ok, w_range_ok, w_tailcase;
    logic          w_head_ok, w_tail_ok, w_p_ok, w_n_ok;

    logic          w_nx_we, w_pv_we, w_bz_we;
    logic [AW-1:0] w_nx_wa, w_pv_wa, w_bz_wa, w_nx_ra, w_pv_ra, w_bz_ra;
    logic [LW-1:0] w_nx_wd, w_pv_wd, w_next_rd, w_prev_rd;
    logic          w_bz_wd, w_busy_rd;

    // newest chunk and its bounds
    assign w_cm1   = r_count - KW'(1);
    assign w_top   = w_cm1[IW-1:0];
    assign w_cidx  = r_count[IW-1:0];
    assign w_nbase = r_base[w_top];
    assign w_nlen  = r_len[w_top];
    assign w_end   = XW'(w_nbase) + XW'(w_nlen);
    assign w_i1    = r_i + LW'(1);
    assign w_last  = XW'(w_i1) == w_end;

    // next chunk: twice the newest, capped
    assign w_dbl    = {w_nlen[CW-2:0], 1'b0};
    assign w_nnew   = (w_dbl > CAP_C) ? CAP_C : w_dbl;
    assign w_act_ok = (r_count < MAXC_K) && ((w_end + XW'(w_nnew)) <= TOT_X);

    assign w_init_len = (r_first == '0) ? CW'(1) :
                        (XW'(r_first) > TOT_X) ? CW'(TOTAL_SLOTS) : CW'(r_first);

    assign w_s_x      = XW'(r_slot);
    assign w_s_l      = LW'(r_slot);
    assign w_range_ok = (w_s_x < TOT_X) && (w_s_x < w_end);
    assign w_tailcase = w_s_x >= XW'(w_nbase);

    assign w_head_ok = r_head != NONE;
    assign w_tail_ok = r_tail != NONE;
    assign w_p_ok    = w_prev_rd != NONE;
    assign w_n_ok    = w_next_rd != NONE;

    always_comb begin
        w_nx_we = 1'b0;
        w_pv_we = 1'b0;
        w_bz_we = 1'b0;
        w_nx_wa = r_i[AW-1:0];
        w_pv_wa = r_i[AW-1:0];
        w_bz_wa = r_i[AW-1:0];
        w_nx_wd = NONE;
        w_pv_wd = NONE;
        w_bz_wd = 1'b0;
        w_nx_ra = r_i[AW-1:0];
        w_pv_ra = r_i[AW-1:0];
        w_bz_ra = r_i[AW-1:0];
        case (i_cmd.op)
            cspa_pkg::OP_LINKHEAD: begin
                w_nx_we = w_tail_ok;
                w_nx_wa = r_tail[AW-1:0];
                w_nx_wd = w_nbase;
            end
            cspa_pkg::OP_LINK: begin
                w_nx_we = 1'b1;
                w_nx_wd = w_last ? NONE : w_i1;
                w_pv_we = 1'b1;
                w_pv_wd = r_lprev;
                w_bz_we = 1'b1;
            end
            cspa_pkg::OP_A_RD: begin
                w_nx_ra = r_head[AW-1:0];
            end
            cspa_pkg::OP_A_UPD: begin
                w_pv_we = w_n_ok;
                w_pv_wa = w_next_rd[AW-1:0];
                w_bz_we = 1'b1;
                w_bz_wa = r_head[AW-1:0];
                w_bz_wd = 1'b1;
            end
            cspa_pkg::OP_F_RD: begin
                w_bz_ra = w_s_l[AW-1:0];
            end
            cspa_pkg::OP_F_W1: begin
                w_nx_we = 1'b1;
                w_nx_wa = w_s_l[AW-1:0];
                w_nx_wd = w_tailcase ? NONE : r_head;
                w_pv_we = 1'b1;
                w_pv_wa = w_s_l[AW-1:0];
                w_pv_wd = w_tailcase ? r_tail : NONE;
                w_bz_we = 1'b1;
                w_bz_wa = w_s_l[AW-1:0];
            end
            cspa_pkg::OP_F_W2: begin
                w_nx_we = w_tailcase && w_tail_ok;
                w_nx_wa = r_tail[AW-1:0];
                w_nx_wd = w_s_l;
                w_pv_we = !w_tailcase && w_head_ok;
                w_pv_wa = r_head[AW-1:0];
                w_pv_wd = w_s_l;
            end
            cspa_pkg::OP_U_WR: begin
                w_nx_we = w_p_ok;
                w_nx_wa = w_prev_rd[AW-1:0];
                w_nx_wd = w_next_rd;
                w_pv_we = w_n_ok;
                w_pv_wa = w_next_rd[AW-1:0];
                w_pv_wd = w_prev_rd;
            end
            default: begin
            end
        endcase
    end

    cspa_ram #(.WIDTH(LW), .DEPTH(TOTAL_SLOTS)) u_next_ram (
        .i_clk(i_clk), .i_we(w_nx_we), .i_waddr(w_nx_wa), .i_wdata(w_nx_wd),
        .i_raddr(w_nx_ra), .o_rdata(w_next_rd)
    );

    cspa_ram #(.WIDTH(LW), .DEPTH(TOTAL_SLOTS)) u_prev_ram (
        .i_clk(i_clk), .i_we(w_pv_we), .i_waddr(w_pv_wa), .i_wdata(w_pv_wd),
        .i_raddr(w_pv_ra), .o_rdata(w_prev_rd)
    );

    cspa_ram #(.WIDTH(1), .DEPTH(TOTAL_SLOTS)) u_busy_ram (
        .i_clk(i_clk), .i_we(w_bz_we), .i_waddr(w_bz_wa), .i_wdata(w_bz_wd),
        .i_raddr(w_bz_ra), .o_rdata(w_busy_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= cspa_pkg::FIRST_RESET;
            r_count     <= KW'(1);
            r_head      <= NONE;
            r_tail      <= NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == cspa_pkg::OP_DONE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                cspa_pkg::OP_CFG: begin
                    r_first <= i_cfg_data;
                end
                cspa_pkg::OP_INIT: begin
                    r_count <= KW'(1);
                    r_head  <= NONE;
                    r_tail  <= NONE;
                end
                cspa_pkg::OP_ACT: begin
                    if (w_act_ok) begin
                        r_count <= r_count + KW'(1);
                    end
                end
                cspa_pkg::OP_LINKHEAD: begin
                    if (!w_tail_ok) begin
                        r_head <= w_nbase;
                    end
                end
                cspa_pkg::OP_LINK: begin
                    if (w_last) begin
                        r_tail <= r_i;
                    end
                end
                cspa_pkg::OP_A_UPD: begin
                    r_head <= w_next_rd;
                    if (!w_n_ok) begin
                        r_tail <= NONE;
                    end
                end
                cspa_pkg::OP_F_W2: begin
                    if (w_tailcase) begin
                        if (!w_tail_ok) begin
                            r_head <= w_s_l;
                        end
                        r_tail <= w_s_l;
                    end else begin
                        if (!w_head_ok) begin
                            r_tail <= w_s_l;
                        end
                        r_head <= w_s_l;
                    end
                end
                cspa_pkg::OP_U_WR: begin
                    if (!w_p_ok) begin
                        r_head <= w_next_rd;
                    end
                    if (!w_n_ok) begin
                        r_tail <= w_prev_rd;
                    end
                    if (w_last) begin
                        r_count <= r_count - KW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cspa_pkg::OP_INIT: begin
                r_base[0] <= '0;
                r_len[0]  <= w_init_len;
            end
            cspa_pkg::OP_ACCEPT: begin
                r_slot    <= i_slot_index;
                r_i       <= w_nbase;
                r_status  <= i_cmd.set_status ? i_cmd.status : cspa_pkg::ST_OK;
                r_granted <= '0;
            end
            cspa_pkg::OP_ACT: begin
                if (w_act_ok) begin
                    r_base[w_cidx] <= w_end[LW-1:0];
                    r_len[w_cidx]  <= w_nnew;
                end
            end
            cspa_pkg::OP_LINKHEAD: begin
                r_i     <= w_nbase;
                r_lprev <= r_tail;
            end
            cspa_pkg::OP_LINK: begin
                r_lprev <= r_i;
                r_i     <= w_i1;
            end
            cspa_pkg::OP_A_UPD: begin
                r_granted <= cspa_pkg::SLOT_W'(r_head);
            end
            cspa_pkg::OP_G_CHK: begin
                r_i <= w_last ? w_nbase : w_i1;
            end
            cspa_pkg::OP_U_WR: begin
                r_i <= w_i1;
            end
            cspa_pkg::OP_DONE: begin
                r_out_status  <= r_status;
                r_out_granted <= r_granted;
                r_out_count   <= cspa_pkg::CNT_W'(r_count);
            end
            default: begin
            end
        endcase
        if (i_cmd.set_status && (i_cmd.op != cspa_pkg::OP_ACCEPT)) begin
            r_status <= i_cmd.status;
        end
    end

    assign o_stat.head_valid = w_head_ok;
    assign o_stat.gc_ok      = r_count > KW'(1);
    assign o_stat.act_ok     = w_act_ok;
    assign o_stat.range_ok   = w_range_ok;
    assign o_stat.busy       = w_busy_rd;
    assign o_stat.last       = w_last;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_slot  = r_out_granted;
    assign o_active_chunks = r_out_count;

endmodule

@@ rtl/cspa_chk.sv @@
// port-level checks of the chunked slot pool allocator, bound to the top level
// depends on cspa_pkg
module cspa_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [cspa_pkg::STATUS_W-1:0]   o_status,
    input logic [cspa_pkg::SLOT_W-1:0]     o_granted_slot,
    input logic [cspa_pkg::CNT_W-1:0]      o_active_chunks,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_granted_slot)
            && $stable(o_active_chunks))
        else $error("result changed while stalled");

    // only a successful request can hand out a slot
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != cspa_pkg::ST_OK |-> o_granted_slot == '0)
        else $error("slot granted with failing status");

    // the first chunk never retires
    a_chunks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_active_chunks != '0)
        else $error("no active chunk reported");

    // a register write starts the relink sweep, no request right after
    a_cfg_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready && !o_cfg_ready)
        else $error("request taken during relink");

endmodule

bind chunked_slot_pool_allocator cspa_chk u_cspa_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_granted_slot  (o_granted_slot),
    .o_active_chunks (o_active_chunks),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready)
);

@@ verif/chunked_slot_pool_allocator_tb.sv @@
// testbench for chunked_slot_pool_allocator: alloc/free/collect/unknown requests
// checked against an in-bench free-list predictor; depends on cspa_pkg, rtl top
module chunked_slot_pool_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 4096;
    localparam int NCHUNK = 16;
    localparam int CAP = 1024;
    localparam int NONE = NSLOT;
    localparam logic [cspa_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        logic [cspa_pkg::REQ_W-1:0]    req;
        logic [cspa_pkg::SLOT_W-1:0]   slot;
        logic [cspa_pkg::STATUS_W-1:0] status;
        logic [cspa_pkg::SLOT_W-1:0]   granted;
        logic [cspa_pkg::CNT_W-1:0]    chunks;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [cspa_pkg::REQ_W-1:0] req_type = '0;
    logic [cspa_pkg::SLOT_W-1:0] slot_index = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [cspa_pkg::CFG_W-1:0] cfg_data = '0;
    logic o_in_ready, o_out_valid, o_cfg_ready;
    logic [cspa_pkg::STATUS_W-1:0] o_status;
    logic [cspa_pkg::SLOT_W-1:0] o_granted_slot;
    logic [cspa_pkg::CNT_W-1:0] o_active_chunks;

    chunked_slot_pool_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_req_type(req_type), .i_slot_index(slot_index),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_status(o_status), .o_granted_slot(o_granted_slot),
        .o_active_chunks(o_active_chunks),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // pool shadow
    int nxt[NSLOT];
    int prv[NSLOT];
    bit busy[NSLOT];
    int cbase[NCHUNK];
    int clen[NCHUNK];
    int ccount, head, tail;
    int held[$];

    t_request pending[$];
    t_request expected[$];
    t_request cur;
    int errors = 0;
    bit calm = 1'b0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit in_fire = 1'b0;

    function automatic logic [cspa_pkg::SLOT_W-1:0] rnd_slot();
        return cspa_pkg::SLOT_W'($urandom);
    endfunction

    function automatic void link_newest();
        int k, s, e, p;
        k = ccount - 1;
        e = cbase[k] + clen[k];
        p = tail;
        for (s = cbase[k]; s < e && s < NSLOT; s++) begin
            busy[s] = 1'b0;
            prv[s] = p;
            if (p < NSLOT) nxt[p] = s;
            else head = s;
            p = s;
        end
        tail = p;
        if (p < NSLOT) nxt[p] = NONE;
    endfunction

    function automatic void pool_init(int first);
        int n;
        n = (first == 0) ? 1 : (first > NSLOT ? NSLOT : first);
        foreach (busy[i]) busy[i] = 1'b0;
        cbase[0] = 0;
        clen[0] = n;
        ccount = 1;
        head = NONE;
        tail = NONE;
        held.delete();
        link_newest();
    endfunction

    function automatic int newest_end();
        return cbase[ccount-1] + clen[ccount-1];
    endfunction

    function automatic bit grow_pool();
        int n, base;
        n = clen[ccount-1] * 2;
        base = newest_end();
        if (n > CAP) n = CAP;
        if (ccount >= NCHUNK) return 1'b0;
        if (base > NSLOT || n > NSLOT - base) return 1'b0;
        cbase[ccount] = base;
        clen[ccount] = n;
        ccount++;
        link_newest();
        return 1'b1;
    endfunction

    function automatic void unlink(int s);
        int p, n;
        p = prv[s];
        n = nxt[s];
        if (p < NSLOT) nxt[p] = n;
        else head = n;
        if (n < NSLOT) prv[n] = p;
        else tail = p;
    endfunction

    function automatic void pool_step(ref t_request r);
        int s, h, n, e;
        s = r.slot;
        r.status = cspa_pkg::ST_OK;
        r.granted = '0;
        case (r.req)
            cspa_pkg::REQ_ALLOC: begin
                if (head == NONE && !grow_pool()) begin
                    r.status = cspa_pkg::ST_NO_SPACE;
                end else begin
                    h = head;
                    n = nxt[h];
                    if (n < NSLOT) begin
                        head = n;
                        prv[n] = NONE;
                    end else begin
                        head = NONE;
                        tail = NONE;
                    end
                    busy[h] = 1'b1;
                    prv[h] = NONE;
                    nxt[h] = NONE;
                    r.granted = cspa_pkg::SLOT_W'(h);
                end
            end
            cspa_pkg::REQ_FREE: begin
                if (s >= newest_end() || !busy[s]) begin
                    r.status = cspa_pkg::ST_INVALID;
                end else begin
                    busy[s] = 1'b0;
                    if (s >= cbase[ccount-1]) begin
                        prv[s] = tail;
                        nxt[s] = NONE;
                        if (tail < NSLOT) nxt[tail] = s;
                        else head = s;
                        tail = s;
                    end else begin
                        nxt[s] = head;
                        prv[s] = NONE;
                        if (head < NSLOT) prv[head] = s;
                        else tail = s;
                        head = s;
                    end
                end
            end
            cspa_pkg::REQ_GC: begin
                if (ccount <= 1) begin
                    r.status = cspa_pkg::ST_NOTHING;
                end else begin
                    e = newest_end();
                    for (int i = cbase[ccount-1]; i < e && i < NSLOT; i++)
                        if (busy[i]) r.status = cspa_pkg::ST_NOTHING;
                    if (r.status == cspa_pkg::ST_OK) begin
                        for (int i = cbase[ccount-1]; i < e && i < NSLOT; i++) unlink(i);
                        ccount--;
                    end
                end
            end
            default: ;
        endcase
        r.chunks = cspa_pkg::CNT_W'(ccount);
    endfunction

    task automatic add_request(logic [cspa_pkg::REQ_W-1:0] req,
                               logic [cspa_pkg::SLOT_W-1:0] slot);
        t_request r;
        r.req = req;
        r.slot = slot;
        pool_step(r);
        if (req == cspa_pkg::REQ_ALLOC && r.status == cspa_pkg::ST_OK)
            held.push_back(r.granted);
        pending.push_back(r);
    endtask

    task automatic free_held(int idx);
        int s;
        s = held[idx];
        held.delete(idx);
        add_request(cspa_pkg::REQ_FREE, cspa_pkg::SLOT_W'(s));
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending.size() != 0 || in_valid || expected.size() != 0);
    endtask

    task automatic write_first_len(logic [cspa_pkg::CFG_W-1:0] v);
        wait_drained();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        pool_init(v);
    endtask

    task automatic random_requests(int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                // release everything so a collect can retire chunks
                while (held.size() > 0) free_held($urandom_range(held.size() - 1));
                repeat ($urandom_range(3, 1)) add_request(cspa_pkg::REQ_GC, rnd_slot());
            end else if (roll < 45) begin
                add_request(cspa_pkg::REQ_ALLOC, rnd_slot());
            end else if (roll < 75 && held.size() > 0) begin
                free_held($urandom_range(held.size() - 1));
            end else if (roll < 83) begin
                add_request(cspa_pkg::REQ_FREE, rnd_slot());
            end else if (roll < 95) begin
                add_request(cspa_pkg::REQ_GC, rnd_slot());
            end else begin
                add_request(REQ_UNKNOWN, rnd_slot());
            end
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (pending.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
                cur = pending.pop_front();
                req_type <= cur.req;
                slot_index <= cur.slot;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = 400;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || $urandom_range(99) >= 29;
        end
    end

    // transfer monitor
    always @(posedge i_clk) begin
        t_request e;
        in_fire <= in_valid && o_in_ready;
        if (in_valid && o_in_ready) expected.push_back(cur);
        if (o_out_valid && out_ready) begin
            if (expected.size() == 0) begin
                $error("result with nothing expected: status %0d", o_status);
                errors++;
            end else begin
                e = expected.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_granted_slot !== e.granted) begin
                    $error("granted_slot: expected %0d, actual %0d", e.granted, o_granted_slot);
                    errors++;
                end
                if (o_active_chunks !== e.chunks) begin
                    $error("active_chunks: expected %0d, actual %0d", e.chunks, o_active_chunks);
                    errors++;
                end
            end
        end
    end

    initial begin
        pool_init(cspa_pkg::FIRST_RESET);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset length, edge slots, unknown type, growth and collect
        add_request(cspa_pkg::REQ_ALLOC, 12'hFFF);
        free_held(0);
        add_request(cspa_pkg::REQ_FREE, 12'd0);
        add_request(cspa_pkg::REQ_FREE, 12'hFFF);
        add_request(cspa_pkg::REQ_GC, '0);
        add_request(REQ_UNKNOWN, 12'hFFF);
        repeat (65) add_request(cspa_pkg::REQ_ALLOC, '0);
        add_request(cspa_pkg::REQ_GC, '0);
        add_request(cspa_pkg::REQ_FREE, 12'd64);
        add_request(cspa_pkg::REQ_FREE, 12'd200);
        add_request(cspa_pkg::REQ_FREE, 12'd5);
        held.delete(64);
        held.delete(4);
        add_request(cspa_pkg::REQ_GC, '0);
        add_request(cspa_pkg::REQ_ALLOC, '0);
        wait_drained();

        // length one, plenty of growth and collects
        write_first_len(11'd1);
        random_requests(100);
        wait_drained();

        // full-size chunks, receiver held off while requests pile up
        write_first_len(11'd1024);
        random_requests(60);
        hold_seq++;
        wait_drained();

        // zero length: several activations in a row
        write_first_len(11'd0);
        repeat (20) add_request(cspa_pkg::REQ_ALLOC, rnd_slot());
        add_request(cspa_pkg::REQ_ALLOC, '0);
        add_request(cspa_pkg::REQ_GC, '0);
        free_held(0);
        free_held(held.size() - 1);
        add_request(cspa_pkg::REQ_ALLOC, '0);
        add_request(cspa_pkg::REQ_ALLOC, '0);
        wait_drained();

        write_first_len(11'd2047);
        random_requests(40);
        wait_drained();

        calm = 1'b1;
        write_first_len(11'($urandom_range(16, 2)));
        random_requests(70);
        wait_drained();
        calm = 1'b0;
        random_requests(70);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
